@@ rtl/wavg_pkg.sv @@
// Shared types, sizes and register map of the windowed average block.
package wavg_pkg;

    // Window depth and derived widths
    localparam int WINDOW     = 8;
    localparam int IDX_W      = $clog2(WINDOW);
    localparam int CNT_W      = $clog2(WINDOW + 1);

    // Field ranges
    localparam int ANGLE_W    = 15;
    localparam int WIND_W     = 13;
    localparam int BOAT_W     = 13;
    localparam int USED_W     = 4;
    localparam int ANGLE_TOP  = 18000;
    localparam int WIND_MAX   = 7000;
    localparam int BOAT_MAX   = 5000;

    // Sum and divider widths; the angle sum is the widest
    localparam int SUM_W      = $clog2(ANGLE_TOP * WINDOW + 1);
    localparam int DIV_CNT_W  = $clog2(SUM_W + 1);

    // Configuration port
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_ADDR_W-1:0] ADDR_ANGLE_BREAK = CFG_ADDR_W'(0);
    localparam logic [ANGLE_W-1:0]    ANGLE_BREAK_RST  = ANGLE_W'(1500);

    // Channel select codes for the shared divider
    typedef enum logic [1:0] {
        CH_ANGLE = 2'd0,
        CH_WIND  = 2'd1,
        CH_BOAT  = 2'd2
    } chan_t;

    // Input beat
    typedef struct packed {
        logic [ANGLE_W-1:0] wind_angle;
        logic [WIND_W-1:0]  wind_speed;
        logic [BOAT_W-1:0]  boat_speed;
    } sample_t;

    // Result beat
    typedef struct packed {
        logic [ANGLE_W-1:0] mean_angle;
        logic [WIND_W-1:0]  mean_wind_speed;
        logic [BOAT_W-1:0]  mean_boat_speed;
        logic [USED_W-1:0]  samples_used;
    } result_t;

    // Divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

@@ rtl/wavg_ring.sv @@
// Sample ring memory: one write port and one registered read port.
module wavg_ring
    import wavg_pkg::*;
(
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  sample_t          wr_data,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_addr,
    output sample_t          rd_data
);

    sample_t mem [WINDOW];
    sample_t rd_data_reg;

    // Store the incoming sample
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Register the read word
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/wavg_div.sv @@
// Shared restoring divider: one quotient bit per cycle, window count divisor.
module wavg_div
    import wavg_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [SUM_W-1:0] dividend,
    input  logic [CNT_W-1:0] divisor,
    output logic [SUM_W-1:0] quotient,
    output div_stat_t        stat
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [SUM_W-1:0]     quo_reg;
    logic [CNT_W-1:0]     rem_reg;
    logic [CNT_W-1:0]     dsr_reg;

    logic [CNT_W:0]       rem_sh;
    logic                 fits;
    logic [CNT_W:0]       rem_sub;
    logic [CNT_W-1:0]     rem_next;
    logic [SUM_W-1:0]     quo_next;

    // Shift one dividend bit into the remainder and try the subtract
    always_comb begin
        rem_sh   = {rem_reg, quo_reg[SUM_W-1]};
        fits     = (rem_sh >= {1'b0, dsr_reg});
        rem_sub  = rem_sh - {1'b0, dsr_reg};
        rem_next = fits ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
        quo_next = {quo_reg[SUM_W-2:0], fits};
    end

    // Control: load on start, count down one step per cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start && !busy_reg) begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(SUM_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        if (start && !busy_reg) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

@@ rtl/windowed_average_with_jump_reset.sv @@
// Each input beat yields one result beat; s_ready is high only in the idle state, so the next
// input beat is taken only after the previous result has been loaded into the output register.
// Rate is set by the summing walk over the ring memory read port (one entry a cycle)
// and by the shared bit-serial divider, used once per channel.
// Synchronous active-low reset empties the window, clears the previous angle and
// sets angle_break to 1500; the ring memory contents are not cleared.
module windowed_average_with_jump_reset
    import wavg_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // input channel
    input  logic                  s_valid,
    output logic                  s_ready,
    input  sample_t               s_data,
    // result channel
    output logic                  m_valid,
    input  logic                  m_ready,
    output result_t               m_data,
    // configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SUM  = 4'b0010,
        S_DIV  = 4'b0100,
        S_OUT  = 4'b1000
    } state_t;

    state_t             state_reg, state_next;

    logic [ANGLE_W-1:0] angle_break_reg;
    logic [CNT_W-1:0]   fill_reg;
    logic [IDX_W-1:0]   widx_reg;
    logic [ANGLE_W-1:0] prev_angle_reg;
    logic               have_prev_reg;

    logic [CNT_W-1:0]   rcnt_reg;
    logic               pend_reg;
    logic [SUM_W-1:0]   sum_angle_reg;
    logic [SUM_W-1:0]   sum_wind_reg;
    logic [SUM_W-1:0]   sum_boat_reg;

    chan_t              chan_reg;
    logic               launch_reg;
    logic [ANGLE_W-1:0] mean_angle_reg;
    logic [WIND_W-1:0]  mean_wind_reg;
    logic [BOAT_W-1:0]  mean_boat_reg;

    logic               m_valid_reg;
    result_t            m_data_reg;

    logic               in_fire;
    logic               cfg_wr;
    sample_t            clamped;
    logic [ANGLE_W-1:0] angle_diff;
    logic               jump;
    logic [IDX_W-1:0]   wr_idx;
    logic               rd_en;
    sample_t            rd_data;
    logic               sum_done;
    logic [SUM_W-1:0]   div_dividend;
    logic [SUM_W-1:0]   div_quotient;
    div_stat_t          div_stat;
    logic               out_load;

    assign in_fire = s_valid && s_ready;
    assign s_ready = (state_reg == S_IDLE);

    // Configuration register write and read-back
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            angle_break_reg <= ANGLE_BREAK_RST;
        end else if (cfg_wr && (paddr == ADDR_ANGLE_BREAK)) begin
            angle_break_reg <= pwdata[ANGLE_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr == ADDR_ANGLE_BREAK) begin
            prdata = CFG_DATA_W'(angle_break_reg);
        end
    end

    // Saturate the incoming fields
    always_comb begin
        clamped.wind_angle = (s_data.wind_angle > ANGLE_W'(ANGLE_TOP)) ?
                             ANGLE_W'(ANGLE_TOP) : s_data.wind_angle;
        clamped.wind_speed = (s_data.wind_speed > WIND_W'(WIND_MAX)) ?
                             WIND_W'(WIND_MAX) : s_data.wind_speed;
        clamped.boat_speed = (s_data.boat_speed > BOAT_W'(BOAT_MAX)) ?
                             BOAT_W'(BOAT_MAX) : s_data.boat_speed;
    end

    // Angle jump test against the previous sample
    always_comb begin
        angle_diff = (clamped.wind_angle > prev_angle_reg) ?
                     (clamped.wind_angle - prev_angle_reg) :
                     (prev_angle_reg - clamped.wind_angle);
        jump   = have_prev_reg && (angle_diff > angle_break_reg);
        wr_idx = jump ? '0 : widx_reg;
    end

    // Window bookkeeping at each input beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg       <= '0;
            widx_reg       <= '0;
            prev_angle_reg <= '0;
            have_prev_reg  <= 1'b0;
        end else if (in_fire) begin
            prev_angle_reg <= clamped.wind_angle;
            have_prev_reg  <= 1'b1;
            widx_reg       <= (wr_idx == IDX_W'(WINDOW - 1)) ? '0 : wr_idx + IDX_W'(1);
            if (jump) begin
                fill_reg <= CNT_W'(1);
            end else if (fill_reg < CNT_W'(WINDOW)) begin
                fill_reg <= fill_reg + CNT_W'(1);
            end
        end
    end

    wavg_ring u_ring (
        .aclk    (aclk),
        .wr_en   (in_fire),
        .wr_addr (wr_idx),
        .wr_data (clamped),
        .rd_en   (rd_en),
        .rd_addr (rcnt_reg[IDX_W-1:0]),
        .rd_data (rd_data)
    );

    // Walk entries 0 to fill-1, one read a cycle
    assign rd_en    = (state_reg == S_SUM) && (rcnt_reg != fill_reg);
    assign sum_done = (state_reg == S_SUM) && (rcnt_reg == fill_reg) && !pend_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rcnt_reg <= '0;
            pend_reg <= 1'b0;
        end else begin
            pend_reg <= rd_en;
            if (in_fire) begin
                rcnt_reg <= '0;
            end else if (rd_en) begin
                rcnt_reg <= rcnt_reg + CNT_W'(1);
            end
        end
    end

    // Accumulate the returned words
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            sum_angle_reg <= '0;
            sum_wind_reg  <= '0;
            sum_boat_reg  <= '0;
        end else if (pend_reg) begin
            sum_angle_reg <= sum_angle_reg + SUM_W'(rd_data.wind_angle);
            sum_wind_reg  <= sum_wind_reg + SUM_W'(rd_data.wind_speed);
            sum_boat_reg  <= sum_boat_reg + SUM_W'(rd_data.boat_speed);
        end
    end

    // Feed one channel sum at a time to the divider
    always_comb begin
        case (chan_reg)
            CH_ANGLE: div_dividend = sum_angle_reg;
            CH_WIND:  div_dividend = sum_wind_reg;
            CH_BOAT:  div_dividend = sum_boat_reg;
            default:  div_dividend = sum_boat_reg;
        endcase
    end

    wavg_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (launch_reg),
        .dividend (div_dividend),
        .divisor  (fill_reg),
        .quotient (div_quotient),
        .stat     (div_stat)
    );

    // Launch each division and collect its quotient
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chan_reg   <= CH_ANGLE;
            launch_reg <= 1'b0;
        end else begin
            launch_reg <= 1'b0;
            if (sum_done) begin
                chan_reg   <= CH_ANGLE;
                launch_reg <= 1'b1;
            end else if ((state_reg == S_DIV) && div_stat.done) begin
                unique case (chan_reg)
                    CH_ANGLE: begin
                        chan_reg   <= CH_WIND;
                        launch_reg <= 1'b1;
                    end
                    CH_WIND: begin
                        chan_reg   <= CH_BOAT;
                        launch_reg <= 1'b1;
                    end
                    default: begin
                        chan_reg <= CH_ANGLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == S_DIV) && div_stat.done) begin
            case (chan_reg)
                CH_ANGLE: mean_angle_reg <= div_quotient[ANGLE_W-1:0];
                CH_WIND:  mean_wind_reg  <= div_quotient[WIND_W-1:0];
                default:  mean_boat_reg  <= div_quotient[BOAT_W-1:0];
            endcase
        end
    end

    // Sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    state_next = S_SUM;
                end
            end
            S_SUM: begin
                if (sum_done) begin
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                if (div_stat.done && (chan_reg == CH_BOAT)) begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (out_load) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Output register: load once the previous result beat has left
    assign out_load = (state_reg == S_OUT) && (!m_valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg.mean_angle      <= mean_angle_reg;
            m_data_reg.mean_wind_speed <= mean_wind_reg;
            m_data_reg.mean_boat_speed <= mean_boat_reg;
            m_data_reg.samples_used    <= USED_W'(fill_reg);
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    // An input beat always starts the summing walk
    a_fire_to_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> (state_reg == S_SUM))
        else $error("input beat did not start the summing walk");

    // The window is never empty and never overfull once an item is at work
    a_fill_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> ((fill_reg != '0) && (fill_reg <= CNT_W'(WINDOW))))
        else $error("fill count out of range while working");

    // The divider is launched only while it is free
    a_div_free: assert property (@(posedge aclk) disable iff (!aresetn)
        launch_reg |-> !div_stat.busy)
        else $error("divider launched while busy");

    // A new result beat comes only from the output state
    a_out_from_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("result beat raised outside the output state");
`endif

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the windowed average block with jump reset.
`timescale 1ns / 100ps

module tb;
    import wavg_pkg::*;

    localparam int HALF_PERIOD = 5;
    localparam int RESET_CYCLES = 9;
    localparam int DRAIN_CYCLES = 80;
    localparam int HOLD_CYCLES = 400;
    localparam int CYCLE_LIMIT = 1500000;
    localparam int PHASES = 8;
    localparam int PHASE_SAMPLES = 215;

    // Predict window means and check each result beat against the oldest one
    class window_mean_board;
        bit [ANGLE_W-1:0] angle_ring [WINDOW];
        bit [WIND_W-1:0]  wind_ring [WINDOW];
        bit [BOAT_W-1:0]  boat_ring [WINDOW];
        int unsigned      fill;
        int unsigned      slot;
        int unsigned      last_angle;
        bit               seen_angle;
        int unsigned      angle_break;
        result_t          expected_means [$];
        int unsigned      mismatches;
        int unsigned      restarts;
        int unsigned      checked;

        function new();
            fill = 0;
            slot = 0;
            last_angle = 0;
            seen_angle = 1'b0;
            angle_break = ANGLE_BREAK_RST;
            mismatches = 0;
            restarts = 0;
            checked = 0;
        endfunction

        function void set_angle_break(logic [CFG_DATA_W-1:0] value);
            angle_break = value[ANGLE_W-1:0];
        endfunction

        function int unsigned clip(int unsigned v, int unsigned top);
            return (v > top) ? top : v;
        endfunction

        function void note_sample(sample_t s);
            int unsigned a;
            int unsigned w;
            int unsigned b;
            int unsigned diff;
            int unsigned sum_a;
            int unsigned sum_w;
            int unsigned sum_b;
            result_t r;
            a = clip(s.wind_angle, ANGLE_TOP);
            w = clip(s.wind_speed, WIND_MAX);
            b = clip(s.boat_speed, BOAT_MAX);
            // Empty the window when the angle jumps by more than the break
            if (seen_angle) begin
                diff = (a > last_angle) ? a - last_angle : last_angle - a;
                if (diff > angle_break) begin
                    fill = 0;
                    slot = 0;
                    restarts++;
                end
            end
            last_angle = a;
            seen_angle = 1'b1;
            // Store the sample and advance the ring
            angle_ring[slot] = a;
            wind_ring[slot] = w;
            boat_ring[slot] = b;
            slot = (slot + 1) % WINDOW;
            if (fill < WINDOW) fill++;
            sum_a = 0;
            sum_w = 0;
            sum_b = 0;
            for (int i = 0; i < fill; i++) begin
                sum_a += angle_ring[i];
                sum_w += wind_ring[i];
                sum_b += boat_ring[i];
            end
            r.mean_angle = ANGLE_W'(sum_a / fill);
            r.mean_wind_speed = WIND_W'(sum_w / fill);
            r.mean_boat_speed = BOAT_W'(sum_b / fill);
            r.samples_used = USED_W'(fill);
            expected_means.push_back(r);
        endfunction

        function void check_mean(result_t got);
            result_t want;
            if (expected_means.size() == 0) begin
                $display("%0t: unexpected result beat %h", $time, got);
                mismatches++;
                return;
            end
            want = expected_means.pop_front();
            checked++;
            if (got.mean_angle !== want.mean_angle) begin
                $display("%0t: mean_angle expected %0d got %0d",
                         $time, want.mean_angle, got.mean_angle);
                mismatches++;
            end
            if (got.mean_wind_speed !== want.mean_wind_speed) begin
                $display("%0t: mean_wind_speed expected %0d got %0d",
                         $time, want.mean_wind_speed, got.mean_wind_speed);
                mismatches++;
            end
            if (got.mean_boat_speed !== want.mean_boat_speed) begin
                $display("%0t: mean_boat_speed expected %0d got %0d",
                         $time, want.mean_boat_speed, got.mean_boat_speed);
                mismatches++;
            end
            if (got.samples_used !== want.samples_used) begin
                $display("%0t: samples_used expected %0d got %0d",
                         $time, want.samples_used, got.samples_used);
                mismatches++;
            end
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    sample_t               s_data;
    logic                  m_valid;
    logic                  m_ready;
    result_t               m_data;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    window_mean_board board;
    int unsigned      send_idle_pct;
    int unsigned      stall_pct;
    int unsigned      hold_request;
    int unsigned      cycle_count;
    int unsigned      reg_errors;
    int unsigned      samples_sent;
    int unsigned      break_settings;
    int unsigned      trail_angle;

    windowed_average_with_jump_reset dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Free-running clock
    initial aclk = 1'b0;
    always #HALF_PERIOD aclk = ~aclk;

    // Count cycles and stop a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Regression FAIL");
            $finish;
        end
    end

    // Watch both channels: note accepted samples, check accepted results
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) board.note_sample(s_data);
            if (m_valid && m_ready) board.check_mean(m_data);
        end
    end

    // Drive m_ready: random stalls, plus a long hold-off on request
    initial begin
        int unsigned seen_req;
        int unsigned hold_left;
        seen_req = 0;
        hold_left = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request != seen_req) begin
                seen_req = hold_request;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Offer one sample beat and hold it until accepted; returns at a falling edge
    task automatic push_sample(sample_t s);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= s;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        samples_sent++;
        trail_angle = (s.wind_angle > ANGLE_TOP) ? ANGLE_TOP : s.wind_angle;
    endtask

    function automatic sample_t pack_sample(int unsigned a, int unsigned w, int unsigned b);
        sample_t s;
        s.wind_angle = ANGLE_W'(a);
        s.wind_speed = WIND_W'(w);
        s.boat_speed = BOAT_W'(b);
        return s;
    endfunction

    // Mostly angle walks inside the break so the window fills; some jumps and noise
    function automatic sample_t pick_sample(int unsigned prev, int unsigned brk);
        sample_t     s;
        int unsigned roll;
        int unsigned step;
        int unsigned span;
        int unsigned a;
        roll = $urandom_range(99);
        span = (brk > ANGLE_TOP) ? ANGLE_TOP : brk;
        s.wind_speed = WIND_W'($urandom_range(WIND_MAX));
        s.boat_speed = BOAT_W'($urandom_range(BOAT_MAX));
        if (roll < 72) begin
            step = $urandom_range(span);
            if ($urandom_range(1)) a = (prev + step > ANGLE_TOP) ? ANGLE_TOP : prev + step;
            else a = (step > prev) ? 0 : prev - step;
            s.wind_angle = ANGLE_W'(a);
        end else if (roll < 82) begin
            s.wind_angle = ANGLE_W'($urandom_range(ANGLE_TOP));
        end else if (roll < 92) begin
            s.wind_angle = ANGLE_W'($urandom);
            s.wind_speed = WIND_W'($urandom);
            s.boat_speed = BOAT_W'($urandom);
        end else begin
            // land exactly on the break or one past it, or jump to either end of the range
            step = span + $urandom_range(1);
            case ($urandom_range(3))
                0: a = (prev + step > ANGLE_TOP) ? ANGLE_TOP : prev + step;
                1: a = (step > prev) ? 0 : prev - step;
                2: a = 0;
                default: a = ANGLE_TOP;
            endcase
            s.wind_angle = ANGLE_W'(a);
        end
        return s;
    endfunction

    // Register write: setup phase, then access phase until pready
    task automatic cfg_write(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_ANGLE_BREAK) board.set_angle_break(data);
        break_settings++;
    endtask

    // Register read in setup and access phases, compared with the tracked break value
    task automatic cfg_read_check(logic [CFG_ADDR_W-1:0] addr);
        logic [CFG_DATA_W-1:0] got;
        logic [CFG_DATA_W-1:0] want;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= addr;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        got = prdata;
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        want = CFG_DATA_W'(board.angle_break);
        if (got !== want) begin
            $display("%0t: angle_break read expected %0d got %0d", $time, want, got);
            reg_errors++;
        end
    endtask

    // Stop offering samples, wait for every expected result, then let the block go quiet
    task automatic drain_results();
        s_valid <= 1'b0;
        while (board.expected_means.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic set_break(logic [CFG_DATA_W-1:0] value);
        drain_results();
        cfg_write(ADDR_ANGLE_BREAK, value);
        cfg_read_check(ADDR_ANGLE_BREAK);
    endtask

    initial begin
        int unsigned break_plan [PHASES];
        board = new();
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        send_idle_pct = 0;
        stall_pct = 0;
        hold_request = 0;
        cycle_count = 0;
        reg_errors = 0;
        samples_sent = 0;
        break_settings = 0;
        trail_angle = 0;
        break_plan = '{1500, 0, ANGLE_TOP, 600, $urandom_range(ANGLE_TOP), 32767, 1,
                       $urandom_range(ANGLE_TOP)};

        // Hold reset, then release at a falling edge
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        cfg_read_check(ADDR_ANGLE_BREAK);

        // Directed: first sample, break boundary, saturation, window wrap
        push_sample(pack_sample(0, 0, 0));
        push_sample(pack_sample(1500, WIND_MAX, BOAT_MAX));
        push_sample(pack_sample(3001, WIND_MAX + 1, BOAT_MAX + 1));
        push_sample(pack_sample(32767, 8191, 8191));
        push_sample(pack_sample(ANGLE_TOP + 1, 0, 0));
        push_sample(pack_sample(16500, 1, 1));
        for (int i = 0; i < 10; i++)
            push_sample(pack_sample(16500 + 100 * i, 700 * i, 500 * i));
        push_sample(pack_sample(0, WIND_MAX, BOAT_MAX));

        // Directed: zero break restarts on any change
        set_break(0);
        push_sample(pack_sample(0, 10, 20));
        push_sample(pack_sample(0, 30, 40));
        push_sample(pack_sample(1, 50, 60));

        // Directed: widest break never restarts; oversize write keeps low bits
        set_break(ANGLE_TOP);
        push_sample(pack_sample(ANGLE_TOP, 8191, 8191));
        push_sample(pack_sample(0, 0, 0));
        push_sample(pack_sample(32767, WIND_MAX, BOAT_MAX));
        set_break(32'hFFFF_FFFF);
        push_sample(pack_sample(0, 0, 0));

        // Random phases over break settings and idle patterns
        for (int ph = 0; ph < PHASES; ph++) begin
            set_break(break_plan[ph]);
            case (ph % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 82; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 82; end
                default: begin send_idle_pct = 35; stall_pct = 35; end
            endcase
            // Back up the result side so the input stalls
            if (ph == 0) hold_request++;
            for (int n = 0; n < PHASE_SAMPLES; n++)
                push_sample(pick_sample(trail_angle, board.angle_break));
        end

        // Collect the tail and report
        drain_results();
        $display("Sent %0d samples, checked %0d means, %0d window restarts",
                 samples_sent, board.checked, board.restarts);
        $display("Break register written %0d times across %0d idle patterns",
                 break_settings, 4);
        if (board.mismatches == 0 && reg_errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/wavg_pkg.sv
rtl/wavg_ring.sv
rtl/wavg_div.sv
rtl/windowed_average_with_jump_reset.sv
tb/tb.sv
